// ----- src/u8esc_pkg.sv -----
package u8esc_pkg;

  localparam int QueueDepthDefault = 2;

  localparam int PosWidth = 4;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_RAW  = 2'd1;
  localparam logic [1:0] TAIL_ESC2 = 2'd2;
  localparam logic [1:0] TAIL_HEX  = 2'd3;

  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_LOW_U  = 7'h75;
  localparam logic [6:0] CH_UP_U   = 7'h55;
  localparam logic [6:0] CH_LOW_X  = 7'h78;
  localparam logic [6:0] CH_LOW_B  = 7'h62;
  localparam logic [6:0] CH_LOW_T  = 7'h74;
  localparam logic [6:0] CH_LOW_N  = 7'h6E;
  localparam logic [6:0] CH_LOW_V  = 7'h76;
  localparam logic [6:0] CH_LOW_F  = 7'h66;
  localparam logic [6:0] CH_LOW_R  = 7'h72;
  localparam logic [6:0] CH_LOW_E  = 7'h65;

  localparam logic [PosWidth-1:0] FLUSH_LEN_NARROW = 4'd6;
  localparam logic [PosWidth-1:0] FLUSH_LEN_WIDE   = 4'd10;

  typedef struct packed {
    logic        flush;
    logic        flush_wide;
    logic [31:0] code;
    logic [1:0]  tail_kind;
    logic [7:0]  tail_byte;
  } cmd_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// ----- src/u8esc_front.sv -----
module u8esc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output logic              push,
  output u8esc_pkg::cmd_t   cmd,
  output logic              code_pending
);

  logic        escape_controls;
  logic [31:0] code_accum;
  logic        code_pending_next;
  logic [31:0] code_accum_next;
  logic        is_cont;
  logic        ctrl;
  logic [6:0]  letter;

  assign is_cont = (in_byte[7:6] == 2'b10);
  assign ctrl    = (in_byte < 8'h20) || (in_byte == 8'h7F);

  always_comb begin
    unique case (in_byte)
      8'h08:   letter = u8esc_pkg::CH_LOW_B;
      8'h09:   letter = u8esc_pkg::CH_LOW_T;
      8'h0A:   letter = u8esc_pkg::CH_LOW_N;
      8'h0B:   letter = u8esc_pkg::CH_LOW_V;
      8'h0C:   letter = u8esc_pkg::CH_LOW_F;
      8'h0D:   letter = u8esc_pkg::CH_LOW_R;
      8'h1B:   letter = u8esc_pkg::CH_LOW_E;
      8'h5C:   letter = u8esc_pkg::CH_BSLASH;
      default: letter = u8esc_pkg::CH_LOW_X;
    endcase
  end

  always_comb begin
    cmd.flush         = 1'b0;
    cmd.flush_wide    = |code_accum[31:16];
    cmd.code          = code_accum;
    cmd.tail_kind     = u8esc_pkg::TAIL_NONE;
    cmd.tail_byte     = in_byte;
    code_pending_next = code_pending;
    code_accum_next   = code_accum;
    if (in_byte == 8'h00) begin
      cmd.flush         = code_pending;
      code_pending_next = 1'b0;
    end else if (code_pending && is_cont) begin
      code_accum_next = {code_accum[25:0], in_byte[5:0]};
    end else begin
      cmd.flush         = code_pending;
      code_pending_next = 1'b0;
      priority if (!in_byte[7]) begin
        if (!escape_controls || !(ctrl || in_byte == 8'h5C)) begin
          cmd.tail_kind = u8esc_pkg::TAIL_RAW;
        end else if (letter == u8esc_pkg::CH_LOW_X) begin
          cmd.tail_kind = u8esc_pkg::TAIL_HEX;
        end else begin
          cmd.tail_kind = u8esc_pkg::TAIL_ESC2;
          cmd.tail_byte = {1'b0, letter};
        end
      end else if (in_byte[7:5] == 3'b110) begin
        code_accum_next   = {27'd0, in_byte[4:0]};
        code_pending_next = 1'b1;
      end else if (in_byte[7:4] == 4'b1110) begin
        code_accum_next   = {28'd0, in_byte[3:0]};
        code_pending_next = 1'b1;
      end else if (in_byte[7:3] == 5'b11110) begin
        code_accum_next   = {29'd0, in_byte[2:0]};
        code_pending_next = 1'b1;
      end else begin
        cmd.tail_kind = u8esc_pkg::TAIL_HEX;
      end
    end
  end

  assign push = accept && (cmd.flush || cmd.tail_kind != u8esc_pkg::TAIL_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_controls <= 1'b1;
      code_pending    <= 1'b0;
      code_accum      <= 32'd0;
    end else begin
      if (cfg_we) begin
        escape_controls <= cfg_data;
      end
      if (accept) begin
        code_pending <= code_pending_next;
        code_accum   <= code_accum_next;
      end
    end
  end

endmodule

// ----- src/u8esc_queue.sv -----
module u8esc_queue #(
  parameter int Depth = u8esc_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8esc_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u8esc_pkg::cmd_t  head_cmd
);

  localparam int PtrWidth   = $clog2(Depth);
  localparam int CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] Full    = CountWidth'(Depth);

  u8esc_pkg::cmd_t        slots [Depth];
  logic [PtrWidth-1:0]    wr_ptr;
  logic [PtrWidth-1:0]    rd_ptr;
  logic [CountWidth-1:0]  count;

  assign full       = (count == Full);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/u8esc_back.sv -----
module u8esc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  u8esc_pkg::cmd_t  head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       out_char,
  output logic             run_last
);

  localparam int W = u8esc_pkg::PosWidth;

  logic [W-1:0] pos;
  logic [W-1:0] flush_len;
  logic [W-1:0] tail_len;
  logic [W-1:0] total;
  logic [W-1:0] tail_pos;
  logic [W-1:0] nib_sel;
  logic [3:0]   code_nib;

  always_comb begin
    if (!head_cmd.flush) begin
      flush_len = '0;
    end else if (head_cmd.flush_wide) begin
      flush_len = u8esc_pkg::FLUSH_LEN_WIDE;
    end else begin
      flush_len = u8esc_pkg::FLUSH_LEN_NARROW;
    end
    unique case (head_cmd.tail_kind)
      u8esc_pkg::TAIL_NONE: tail_len = W'(0);
      u8esc_pkg::TAIL_RAW:  tail_len = W'(1);
      u8esc_pkg::TAIL_ESC2: tail_len = W'(2);
      u8esc_pkg::TAIL_HEX:  tail_len = W'(4);
      default:              tail_len = W'(0);
    endcase
  end

  assign total    = flush_len + tail_len;
  assign tail_pos = pos - flush_len;
  assign nib_sel  = flush_len - W'(1) - pos;
  assign code_nib = head_cmd.code[{nib_sel[2:0], 2'b00} +: 4];

  always_comb begin
    out_char = u8esc_pkg::CH_BSLASH;
    if (pos < flush_len) begin
      if (pos == W'(1)) begin
        out_char = head_cmd.flush_wide ? u8esc_pkg::CH_UP_U : u8esc_pkg::CH_LOW_U;
      end else if (pos != W'(0)) begin
        out_char = u8esc_pkg::hex_char(code_nib);
      end
    end else begin
      unique case (head_cmd.tail_kind)
        u8esc_pkg::TAIL_RAW: out_char = head_cmd.tail_byte[6:0];
        u8esc_pkg::TAIL_ESC2: begin
          if (tail_pos != W'(0)) begin
            out_char = head_cmd.tail_byte[6:0];
          end
        end
        u8esc_pkg::TAIL_HEX: begin
          if (tail_pos == W'(1)) begin
            out_char = u8esc_pkg::CH_LOW_X;
          end else if (tail_pos == W'(2)) begin
            out_char = u8esc_pkg::hex_char(head_cmd.tail_byte[7:4]);
          end else if (tail_pos == W'(3)) begin
            out_char = u8esc_pkg::hex_char(head_cmd.tail_byte[3:0]);
          end
        end
        default: out_char = u8esc_pkg::CH_BSLASH;
      endcase
    end
  end

  assign out_valid = head_valid;
  assign run_last  = (pos == total - W'(1));
  assign pop       = out_valid && out_ready && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (out_valid && out_ready) begin
      pos <= run_last ? '0 : pos + W'(1);
    end
  end

endmodule

// ----- src/utf8_escape_transcoder_unit.sv -----
// UTF-8 to escaped-ASCII transcoder. Takes one byte per item on in_*; a zero
// byte ends the string and closes any open code point. Gives ASCII characters
// on out_*, with run_last marking the last character caused by a byte. The
// front end accepts a byte every cycle while its command queue (QUEUE_DEPTH
// entries) has room; the back end emits one character per cycle while
// out_ready is high. A byte yields 1 character for plain text, 2 for a short
// escape, 4 for \xNN, and a closed code point adds 6 (\uXXXX) or 10
// (\UXXXXXXXX). Lead bytes and continuation bytes of an open code point yield
// none. escape_controls resets to 1 and is written through cfg_we.
module utf8_escape_transcoder_unit #(
  parameter int QUEUE_DEPTH = u8esc_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       run_last
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  logic             code_pending;
  u8esc_pkg::cmd_t  push_cmd;
  u8esc_pkg::cmd_t  head_cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8esc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .in_byte      (in_byte),
    .push         (push),
    .cmd          (push_cmd),
    .code_pending (code_pending)
  );

  u8esc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  u8esc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_last   (run_last)
  );

  assert property (@(posedge clk) disable iff (rst)
    (accept && code_pending && in_byte[7:6] == 2'b10) |-> !push)
    else $error("continuation byte queued output");

  assert property (@(posedge clk) disable iff (rst)
    (accept && in_byte == 8'h00) |=> !code_pending)
    else $error("code point open after terminator");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !run_last) |=> out_valid)
    else $error("run ended without last character");

endmodule

// ----- tb/utf8_escape_transcoder_unit_tb.sv -----
module utf8_escape_transcoder_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  class escaped_text_model;
    bit escape_on = 1'b1;
    bit cp_open;
    bit [31:0] cp_value;
    text_char_t due_chars[$];
    int mismatches;
    int chars_matched;
    int bytes_taken;
    string hex_digits = "0123456789abcdef";

    function void push(logic [6:0] c);
      text_char_t t;
      t.ch = c;
      t.last = 1'b0;
      due_chars.push_back(t);
    endfunction

    function void push_hex(logic [31:0] v, int digits);
      for (int i = digits - 1; i >= 0; i--) begin
        push(7'(hex_digits[(v >> (4 * i)) & 32'hF]));
      end
    endfunction

    function void close_code_point();
      if (!cp_open) return;
      push(u8esc_pkg::CH_BSLASH);
      if (cp_value > 32'hFFFF) begin
        push(u8esc_pkg::CH_UP_U);
        push_hex(cp_value, 8);
      end else begin
        push(u8esc_pkg::CH_LOW_U);
        push_hex(cp_value, 4);
      end
      cp_open = 1'b0;
    endfunction

    function void put_ascii(logic [7:0] b);
      logic [6:0] letter;
      bit ctrl;
      ctrl = (b < 8'h20) || (b == 8'h7F);
      if (!escape_on || !(ctrl || b[6:0] == u8esc_pkg::CH_BSLASH)) begin
        push(b[6:0]);
        return;
      end
      push(u8esc_pkg::CH_BSLASH);
      case (b)
        8'h08: letter = u8esc_pkg::CH_LOW_B;
        8'h09: letter = u8esc_pkg::CH_LOW_T;
        8'h0A: letter = u8esc_pkg::CH_LOW_N;
        8'h0B: letter = u8esc_pkg::CH_LOW_V;
        8'h0C: letter = u8esc_pkg::CH_LOW_F;
        8'h0D: letter = u8esc_pkg::CH_LOW_R;
        8'h1B: letter = u8esc_pkg::CH_LOW_E;
        8'h5C: letter = u8esc_pkg::CH_BSLASH;
        default: letter = u8esc_pkg::CH_LOW_X;
      endcase
      push(letter);
      if (letter == u8esc_pkg::CH_LOW_X) push_hex({24'd0, b}, 2);
    endfunction

    function void take_byte(logic [7:0] b);
      int first;
      text_char_t t;
      first = due_chars.size();
      bytes_taken++;
      if (b == 8'd0) begin
        close_code_point();
      end else if (cp_open && b[7:6] == 2'b10) begin
        cp_value = {cp_value[25:0], b[5:0]};
      end else begin
        close_code_point();
        if (!b[7]) begin
          put_ascii(b);
        end else if (b[7:5] == 3'b110) begin
          cp_value = {27'd0, b[4:0]};
          cp_open = 1'b1;
        end else if (b[7:4] == 4'b1110) begin
          cp_value = {28'd0, b[3:0]};
          cp_open = 1'b1;
        end else if (b[7:3] == 5'b11110) begin
          cp_value = {29'd0, b[2:0]};
          cp_open = 1'b1;
        end else begin
          push(u8esc_pkg::CH_BSLASH);
          push(u8esc_pkg::CH_LOW_X);
          push_hex({24'd0, b}, 2);
        end
      end
      if (due_chars.size() > first) begin
        t = due_chars.pop_back();
        t.last = 1'b1;
        due_chars.push_back(t);
      end
    endfunction

    function void report(string what, logic [6:0] c, logic l, text_char_t want);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s got char %h last %b, expected char %h last %b",
                 what, c, l, want.ch, want.last);
      end
    endfunction

    function void match_char(logic [6:0] c, logic l);
      text_char_t want;
      if (due_chars.size() == 0) begin
        want = '0;
        report("unexpected", c, l, want);
        return;
      end
      want = due_chars.pop_front();
      if (want.ch !== c || want.last !== l) begin
        report("wrong", c, l, want);
      end else begin
        chars_matched++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_char;
  logic       run_last;

  escaped_text_model text_model;
  bit send_idle;
  bit recv_idle;
  bit hold_req;
  int cycles;
  int long_holds;
  int settings_used;

  utf8_escape_transcoder_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .run_last(run_last)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'd0;
    out_ready = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) text_model.match_char(out_char, run_last);
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        long_holds++;
        out_ready <= 1'b0;
        n = LONG_HOLD;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 8);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    text_model.take_byte(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (text_model.due_chars.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_escape(input logic v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_model.escape_on = v;
    settings_used++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic send_random_unit();
    int k;
    int len;
    logic [7:0] b;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      case ($urandom_range(0, 5))
        0: b = 8'($urandom_range(1, 31));
        1: b = ($urandom_range(0, 1) == 0) ? 8'h5C : 8'h7F;
        default: b = 8'($urandom_range(1, 127));
      endcase
      send_byte(b);
    end else if (k < 75) begin
      len = $urandom_range(2, 4);
      case (len)
        2: send_byte({3'b110, 5'($urandom_range(0, 31))});
        3: send_byte({4'b1110, 4'($urandom_range(0, 15))});
        default: send_byte({5'b11110, 3'($urandom_range(0, 7))});
      endcase
      if ($urandom_range(0, 7) == 0) len = len + $urandom_range(1, 4);
      repeat (len - 1) send_byte(cont_byte());
    end else if (k < 82) begin
      send_byte(8'd0);
    end else if (k < 88) begin
      send_byte(cont_byte());
    end else if (k < 94) begin
      send_byte(8'($urandom_range(248, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = text_model.bytes_taken + count;
    while (text_model.bytes_taken < stop_at) send_random_unit();
  endtask

  initial begin
    logic [7:0] opening[$];
    text_model = new();
    opening = '{8'h41, 8'h5C, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h1B,
                8'h01, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h7E,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h80, 8'hFF, 8'hC0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_escape(1'b1);
    foreach (opening[i]) send_byte(opening[i]);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    set_escape(1'b0);
    send_byte(8'h08);
    send_byte(8'h5C);
    send_byte(8'h1F);
    send_byte(8'h7F);
    drain();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_escape(1'b1);
    run_random(90);
    drain();

    set_escape(1'b0);
    run_random(40);
    send_idle = 1'b0;
    hold_req = 1'b1;
    run_random(40);
    send_idle = 1'b1;
    run_random(20);
    drain();

    set_escape(1'b1);
    run_random(90);
    drain();

    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_escape(1'b0);
    run_random(30);
    drain();
    set_escape(1'b1);
    run_random(30);
    send_byte(8'h00);
    drain();

    $display("covered %0d input bytes and %0d output characters across %0d escape settings",
             text_model.bytes_taken, text_model.chars_matched, settings_used);
    $display("long receiver holds: %0d, mismatches: %0d, leftover expected: %0d",
             long_holds, text_model.mismatches, text_model.due_chars.size());
    if (text_model.mismatches == 0 && text_model.due_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/u8esc_pkg.sv
src/u8esc_front.sv
src/u8esc_queue.sv
src/u8esc_back.sv
src/utf8_escape_transcoder_unit.sv
tb/utf8_escape_transcoder_unit_tb.sv
